FILE: src/lsbs_pkg.sv
// Shared types and constants for the single-wire LED strip serializer.
// No dependencies; imported by the top level.
package lsbs_pkg;

  localparam int unsigned FrameBytes = 768;
  localparam int unsigned Rows       = (FrameBytes + 2) / 3;
  localparam int unsigned LoadRows   = FrameBytes / 3;
  localparam int unsigned RowAw      = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned WrowW      = $clog2(LoadRows + 1);
  localparam int unsigned CmpW       = RowAw + 1;
  localparam int unsigned LastRow    = (FrameBytes - 1) / 3;
  localparam int unsigned LastSub    = (FrameBytes - 1) % 3;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_SEND = 2'd1,
    ACT_TICK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    REG_ONE_HIGH  = 3'd0,
    REG_ONE_LOW   = 3'd1,
    REG_ZERO_HIGH = 3'd2,
    REG_ZERO_LOW  = 3'd3,
    REG_LATCH     = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    SUB_GREEN = 2'd0,
    SUB_RED   = 2'd1,
    SUB_BLUE  = 2'd2
  } sub_e;

endpackage

FILE: src/lsbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
module lsbs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/led_strip_bit_serializer.sv
// Single-wire LED strip serializer: pixel store, bit timing and latch sequencer.
// Depends on lsbs_pkg and lsbs_ram (one pixel of green, red, blue per row).
//
//  channel | dir | signals                        | transfer
//  --------+-----+--------------------------------+-------------------------------
//  s_axis  | in  | tdata pixel_color, tuser action| tvalid & tready
//  m_axis  | out | tdata level/busy/rejected, tlast| tvalid & tready
//  cfg     | in  | cfg_index_i, cfg_data_i        | cfg_valid_i & cfg_ready_o
//
// One item per cycle; a result sits in the output register until taken and the
// next item is accepted in the same cycle the result leaves.
// A send or row change issues one row read; the RAM output holds the row until
// the next read. Rows at or above the fill mark read as zero, so no clearing pass.
// Reset: registers to defaults, sequencer idle, store empty.
module led_strip_bit_serializer
  import lsbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] pixel_color
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] line_level, [1] busy_res, [2] rejected
  output logic        m_axis_tlast,   // frame_done
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]  one_high_q, one_low_q, zero_high_q, zero_low_q;
  logic [15:0] latch_q;

  phase_e           phase_q, phase_d;
  logic [15:0]      cnt_q, cnt_d;
  logic [2:0]       bit_q, bit_d;
  logic [RowAw-1:0] srow_q, srow_d;
  sub_e             sub_q, sub_d;
  logic [WrowW-1:0] wrow_q, wrow_d;
  logic [WrowW-1:0] fill_q, fill_d;
  logic             rd_ok_q, rd_ok_d;

  logic out_valid_q, out_valid_d;
  logic level_q, level_d, busy_q, busy_d, done_q, done_d, rej_q, rej_d;

  logic             accept;
  action_e          action;
  logic             ram_we, ram_re;
  logic [RowAw-1:0] ram_raddr, ram_waddr;
  logic [23:0]      ram_wdata, ram_rdata;
  logic [CmpW-1:0]  wrow_ext, rd_cmp, fill_cmp;
  logic [7:0]       cur_byte;
  logic             cur_bit;
  logic [15:0]      cnt_inc, lim;
  logic             last_byte;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign action        = action_e'(s_axis_tuser);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, rej_q, busy_q, level_q};
  assign m_axis_tlast  = done_q;

  assign wrow_ext  = CmpW'(wrow_q);
  assign ram_waddr = wrow_ext[RowAw-1:0];
  assign ram_wdata = {s_axis_tdata[7:0], s_axis_tdata[23:16], s_axis_tdata[15:8]};
  assign rd_cmp    = CmpW'(ram_raddr);
  assign fill_cmp  = CmpW'(fill_q);
  assign cnt_inc   = cnt_q + 16'd1;
  assign last_byte = (srow_q == RowAw'(LastRow)) && (sub_q == sub_e'(LastSub));

  always_comb begin
    case (sub_q)
      SUB_GREEN: cur_byte = ram_rdata[7:0];
      SUB_RED:   cur_byte = ram_rdata[15:8];
      SUB_BLUE:  cur_byte = ram_rdata[23:16];
      default:   cur_byte = 8'd0;
    endcase
    cur_bit = rd_ok_q && cur_byte[bit_q];
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    srow_d      = srow_q;
    sub_d       = sub_q;
    wrow_d      = wrow_q;
    fill_d      = fill_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = srow_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    level_d     = level_q;
    busy_d      = busy_q;
    done_d      = done_q;
    rej_d       = rej_q;
    lim         = 16'd0;

    if (accept) begin
      out_valid_d = 1'b1;
      level_d     = 1'b0;
      busy_d      = (phase_q != PH_IDLE);
      done_d      = 1'b0;
      rej_d       = 1'b0;
      case (action)
        ACT_LOAD: begin
          if (phase_q != PH_IDLE || wrow_q >= WrowW'(LoadRows)) begin
            rej_d = 1'b1;
          end else begin
            ram_we = 1'b1;
            wrow_d = wrow_q + WrowW'(1);
            if (wrow_q == fill_q) begin
              fill_d = fill_q + WrowW'(1);
            end
          end
        end
        ACT_SEND: begin
          busy_d = 1'b1;
          if (phase_q != PH_IDLE) begin
            rej_d = 1'b1;
          end else begin
            srow_d    = '0;
            sub_d     = SUB_GREEN;
            bit_d     = 3'd7;
            cnt_d     = 16'd0;
            phase_d   = PH_HIGH;
            ram_re    = 1'b1;
            ram_raddr = '0;
          end
        end
        ACT_TICK: begin
          case (phase_q)
            PH_HIGH: begin
              level_d = 1'b1;
              lim     = {8'd0, cur_bit ? one_high_q : zero_high_q};
              cnt_d   = cnt_inc;
              if (cnt_inc >= lim) begin
                cnt_d   = 16'd0;
                phase_d = PH_LOW;
              end
            end
            PH_LOW: begin
              lim   = {8'd0, cur_bit ? one_low_q : zero_low_q};
              cnt_d = cnt_inc;
              if (cnt_inc >= lim) begin
                cnt_d   = 16'd0;
                phase_d = PH_HIGH;
                if (bit_q == 3'd0) begin
                  bit_d = 3'd7;
                  if (last_byte) begin
                    phase_d = PH_LATCH;
                  end else if (sub_q == SUB_BLUE) begin
                    sub_d     = SUB_GREEN;
                    srow_d    = srow_q + RowAw'(1);
                    ram_re    = 1'b1;
                    ram_raddr = srow_q + RowAw'(1);
                  end else begin
                    sub_d = sub_e'(sub_q + 2'd1);
                  end
                end else begin
                  bit_d = bit_q - 3'd1;
                end
              end
            end
            PH_LATCH: begin
              cnt_d = cnt_inc;
              if (cnt_inc >= latch_q) begin
                cnt_d   = 16'd0;
                phase_d = PH_IDLE;
                srow_d  = '0;
                sub_d   = SUB_GREEN;
                bit_d   = 3'd7;
                wrow_d  = '0;
                done_d  = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    rd_ok_d = ram_re ? (rd_cmp < fill_cmp) : rd_ok_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= 16'd0;
      bit_q       <= 3'd7;
      srow_q      <= '0;
      sub_q       <= SUB_GREEN;
      wrow_q      <= '0;
      fill_q      <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      srow_q      <= srow_d;
      sub_q       <= sub_d;
      wrow_q      <= wrow_d;
      fill_q      <= fill_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    busy_q  <= busy_d;
    done_q  <= done_d;
    rej_q   <= rej_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q  <= 8'd6;
      one_low_q   <= 8'd3;
      zero_high_q <= 8'd3;
      zero_low_q  <= 8'd7;
      latch_q     <= 16'd400;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_e'(cfg_index_i))
        REG_ONE_HIGH:  one_high_q  <= cfg_data_i[7:0];
        REG_ONE_LOW:   one_low_q   <= cfg_data_i[7:0];
        REG_ZERO_HIGH: zero_high_q <= cfg_data_i[7:0];
        REG_ZERO_LOW:  zero_low_q  <= cfg_data_i[7:0];
        REG_LATCH:     latch_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lsbs_ram #(
    .WIDTH(24),
    .DEPTH(Rows),
    .AW   (RowAw)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
